### design/adsr_pkg.sv
`default_nettype none
package adsr_pkg;

	typedef enum logic [1:0] {
		MODE_TICK     = 2'd0,
		MODE_NOTE_ON  = 2'd1,
		MODE_NOTE_OFF = 2'd2,
		MODE_KILL     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_ATTACK  = 2'd0,
		ST_DECAY   = 2'd1,
		ST_SUSTAIN = 2'd2,
		ST_RELEASE = 2'd3
	} stage_t;

	typedef enum logic [2:0] {
		REG_ATTACK_PACE  = 3'd0,
		REG_DECAY_PACE   = 3'd1,
		REG_SUSTAIN_DROP = 3'd2,
		REG_RELEASE_PACE = 3'd3,
		REG_NOTE_LENGTH  = 3'd4
	} reg_idx_t;

	localparam int unsigned AddrWidth  = 5;
	localparam int unsigned DataWidth  = 32;
	localparam logic [6:0]  LenBase    = 7'd64;
	localparam int unsigned LenScaleSh = 2;

	typedef struct packed {
		logic [2:0] attack_pace;
		logic [2:0] decay_pace;
		logic [3:0] sustain_drop;
		logic [2:0] release_pace;
		logic [5:0] note_length;
	} cfg_t;

	typedef struct packed {
		logic [3:0] level;
		stage_t     phase;
		logic       rising;
		logic       phase_advanced;
	} result_t;

endpackage
`default_nettype wire

### design/adsr_in_if.sv
`default_nettype none
interface adsr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [3:0] note_volume;

	modport source (output valid, output mode, output note_volume, input ready);
	modport sink (input valid, input mode, input note_volume, output ready);
endinterface
`default_nettype wire

### design/adsr_out_if.sv
`default_nettype none
interface adsr_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] level;
	logic [1:0] phase;
	logic       rising;
	logic       phase_advanced;

	modport source (output valid, output level, output phase, output rising,
		output phase_advanced, input ready);
	modport sink (input valid, input level, input phase, input rising,
		input phase_advanced, output ready);
endinterface
`default_nettype wire

### design/adsr_regs.sv
`default_nettype none
module adsr_regs
	import adsr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [AddrWidth-1:0] paddr,
	input  wire logic [DataWidth-1:0] pwdata,
	output logic      [DataWidth-1:0] prdata,
	output logic                      pready,
	output cfg_t                      cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[AddrWidth-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_ATTACK_PACE:  cfg_q.attack_pace  <= pwdata[2:0];
				REG_DECAY_PACE:   cfg_q.decay_pace   <= pwdata[2:0];
				REG_SUSTAIN_DROP: cfg_q.sustain_drop <= pwdata[3:0];
				REG_RELEASE_PACE: cfg_q.release_pace <= pwdata[2:0];
				REG_NOTE_LENGTH:  cfg_q.note_length  <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_ATTACK_PACE:  prdata[2:0] = cfg_q.attack_pace;
			REG_DECAY_PACE:   prdata[2:0] = cfg_q.decay_pace;
			REG_SUSTAIN_DROP: prdata[3:0] = cfg_q.sustain_drop;
			REG_RELEASE_PACE: prdata[2:0] = cfg_q.release_pace;
			REG_NOTE_LENGTH:  prdata[5:0] = cfg_q.note_length;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### design/adsr_core.sv
`default_nettype none
module adsr_core
	import adsr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire mode_t      mode,
	input  wire logic [3:0] note_volume,
	input  wire cfg_t       cfg,
	output result_t         res
);

	stage_t     stage_q, stage_n;
	logic       dir_q, dir_n;
	logic [2:0] pace_q, pace_n;
	logic [2:0] timer_q, timer_n;
	logic [3:0] vol_q, vol_n;
	logic [3:0] target_q, target_n;
	logic [7:0] len_q, len_n;
	logic       adv;

	logic [7:0] len_dec;
	logic [2:0] timer_dec;
	logic [3:0] vol_step;
	logic       done;
	logic [5:0] len_span;

	always_comb begin
		stage_n   = stage_q;
		dir_n     = dir_q;
		pace_n    = pace_q;
		timer_n   = timer_q;
		vol_n     = vol_q;
		target_n  = target_q;
		len_n     = len_q;
		adv       = 1'b0;
		len_dec   = len_q - 8'd1;
		timer_dec = timer_q - 3'd1;
		vol_step  = vol_q;
		done      = 1'b0;
		len_span  = 6'(LenBase - {1'b0, cfg.note_length});

		unique case (mode)
			MODE_TICK: begin
				if (len_q != 8'd0) begin
					len_n = len_dec;
				end
				if (len_q != 8'd0 && len_dec == 8'd0) begin
					vol_n    = 4'd0;
					target_n = 4'd0;
					dir_n    = 1'b1;
					timer_n  = 3'd0;
				end else if (timer_q != 3'd0) begin
					timer_n = timer_dec;
					if (timer_dec == 3'd0) begin
						priority if (vol_q == target_q) begin
							done = 1'b1;
						end else if (dir_q) begin
							if (vol_q == 4'd15) begin
								done = 1'b1;
							end else begin
								vol_step = vol_q + 4'd1;
								done     = (vol_step == target_q);
							end
						end else begin
							if (vol_q == 4'd0) begin
								done = 1'b1;
							end else begin
								vol_step = vol_q - 4'd1;
								done     = (vol_step == target_q);
							end
						end
						vol_n = vol_step;
						if (!done) begin
							timer_n = pace_q;
						end else begin
							priority if (stage_q == ST_ATTACK && cfg.decay_pace != 3'd0
									&& cfg.sustain_drop != 4'd0) begin
								stage_n  = ST_DECAY;
								dir_n    = 1'b0;
								pace_n   = cfg.decay_pace;
								timer_n  = cfg.decay_pace;
								target_n = (vol_step > cfg.sustain_drop)
									? vol_step - cfg.sustain_drop : 4'd0;
								adv      = 1'b1;
							end else if ((stage_q == ST_ATTACK || stage_q == ST_DECAY)
									&& cfg.sustain_drop != 4'd0) begin
								stage_n = ST_SUSTAIN;
								dir_n   = 1'b1;
								pace_n  = 3'd0;
								timer_n = 3'd0;
								adv     = 1'b1;
							end else if (stage_q != ST_RELEASE
									&& cfg.release_pace != 3'd0) begin
								stage_n  = ST_RELEASE;
								dir_n    = 1'b0;
								pace_n   = cfg.release_pace;
								timer_n  = cfg.release_pace;
								target_n = 4'd0;
								adv      = 1'b1;
							end else begin
								vol_n    = 4'd0;
								target_n = 4'd0;
								dir_n    = 1'b1;
								timer_n  = 3'd0;
							end
						end
					end
				end
			end
			MODE_NOTE_ON: begin
				len_n    = (cfg.note_length != 6'd0) ? {len_span, LenScaleSh'(0)} : 8'd0;
				stage_n  = ST_ATTACK;
				dir_n    = 1'b1;
				pace_n   = cfg.attack_pace;
				timer_n  = cfg.attack_pace;
				vol_n    = (cfg.attack_pace != 3'd0) ? 4'd0 : note_volume;
				target_n = note_volume;
			end
			MODE_NOTE_OFF: begin
				if (stage_q != ST_RELEASE) begin
					stage_n = ST_RELEASE;
					if (vol_q == 4'd0 || cfg.release_pace == 3'd0) begin
						vol_n    = 4'd0;
						target_n = 4'd0;
						dir_n    = 1'b1;
						timer_n  = 3'd0;
					end else begin
						dir_n    = 1'b0;
						pace_n   = cfg.release_pace;
						timer_n  = cfg.release_pace;
						target_n = 4'd0;
					end
				end
			end
			MODE_KILL: begin
				vol_n    = 4'd0;
				target_n = 4'd0;
				dir_n    = 1'b1;
				timer_n  = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= ST_RELEASE;
			dir_q    <= 1'b1;
			pace_q   <= 3'd0;
			timer_q  <= 3'd0;
			vol_q    <= 4'd0;
			target_q <= 4'd0;
			len_q    <= 8'd0;
		end else if (step) begin
			stage_q  <= stage_n;
			dir_q    <= dir_n;
			pace_q   <= pace_n;
			timer_q  <= timer_n;
			vol_q    <= vol_n;
			target_q <= target_n;
			len_q    <= len_n;
		end
	end

	assign res.level          = vol_n;
	assign res.phase          = stage_n;
	assign res.rising         = dir_n;
	assign res.phase_advanced = adv;

endmodule
`default_nettype wire

### design/adsr_envelope_stepper.sv
`default_nettype none
// adsr envelope stepper
// cmd channel: one item per tick, note-on, note-off or kill (mode, note_volume)
// env channel: one result item per command item (level, phase, rising,
//   phase_advanced), in command order
// apb port: five envelope settings; the user must write them only while the block is
//   idle, which the block does not enforce; pready is always high
// path: an accepted item waits in the input register until the result register is free,
//   then its result is registered for env (one input register, one result register)
// throughput: one item per cycle while env is not stalled; the envelope state updates
//   as each item steps, so each item sees the state left by the one before it
// reset: envelope in release at level 0 with direction up, settings 0,
//   no item held
// when env stalls the result holds, one more item waits in the input
//   register, and cmd.ready falls after that
module adsr_envelope_stepper
	import adsr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	adsr_in_if.sink                   cmd,
	adsr_out_if.source                env,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [AddrWidth-1:0] paddr,
	input  wire logic [DataWidth-1:0] pwdata,
	output logic      [DataWidth-1:0] prdata,
	output logic                      pready
);

	cfg_t       cfg;
	logic       v_s1;
	mode_t      mode_s1;
	logic [3:0] vol_s1;
	logic       out_v_q;
	result_t    res;
	result_t    res_q;
	logic       step;

	adsr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign step      = v_s1 && (!out_v_q || env.ready);
	assign cmd.ready = !v_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_s1 <= MODE_TICK;
			vol_s1  <= 4'd0;
		end else if (cmd.ready && cmd.valid) begin
			mode_s1 <= mode_t'(cmd.mode);
			vol_s1  <= cmd.note_volume;
		end
	end

	adsr_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.mode        (mode_s1),
		.note_volume (vol_s1),
		.cfg         (cfg),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (!out_v_q || env.ready) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign env.valid          = out_v_q;
	assign env.level          = res_q.level;
	assign env.phase          = res_q.phase;
	assign env.rising         = res_q.rising;
	assign env.phase_advanced = res_q.phase_advanced;

endmodule
`default_nettype wire

### verif/testbench.sv
`default_nettype none
module testbench
	import adsr_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		mode_t      mode;
		logic [3:0] note_volume;
	} cmd_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrWidth-1:0] paddr;
	logic [DataWidth-1:0] pwdata;
	logic [DataWidth-1:0] prdata;
	logic                 pready;

	adsr_in_if  cmd_bus ();
	adsr_out_if env_bus ();

	adsr_envelope_stepper u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_bus),
		.env     (env_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cmd_item_t pending_cmds[$];
	result_t   envelope_expected[$];
	int        error_count = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	logic      hold_req = 1'b0;
	logic      hold_ack = 1'b0;
	int        hold_count = 0;

	// envelope predictor state
	cfg_t       env_cfg = '0;
	stage_t     stage_q = ST_RELEASE;
	logic       dir_up_q = 1'b1;
	logic [2:0] pace_q = '0;
	logic [2:0] timer_q = '0;
	logic [3:0] vol_q = '0;
	logic [3:0] tgt_q = '0;
	logic [7:0] len_q = '0;

	function automatic void note_end();
		vol_q = '0;
		tgt_q = '0;
		dir_up_q = 1'b1;
		timer_q = '0;
	endfunction

	function automatic void start_release();
		stage_q = ST_RELEASE;
		dir_up_q = 1'b0;
		pace_q = env_cfg.release_pace;
		timer_q = env_cfg.release_pace;
		tgt_q = '0;
	endfunction

	function automatic logic next_stage();
		stage_t s;
		s = stage_q;
		if (s == ST_ATTACK) begin
			if (env_cfg.decay_pace != 0 && env_cfg.sustain_drop != 0) begin
				stage_q = ST_DECAY;
				dir_up_q = 1'b0;
				pace_q = env_cfg.decay_pace;
				timer_q = env_cfg.decay_pace;
				tgt_q = (vol_q > env_cfg.sustain_drop) ? vol_q - env_cfg.sustain_drop : 4'd0;
				return 1'b1;
			end
			s = ST_DECAY;
		end
		if (s == ST_DECAY) begin
			if (env_cfg.sustain_drop != 0) begin
				stage_q = ST_SUSTAIN;
				dir_up_q = 1'b1;
				pace_q = '0;
				timer_q = '0;
				return 1'b1;
			end
			s = ST_SUSTAIN;
		end
		if (s == ST_SUSTAIN && env_cfg.release_pace != 0) begin
			start_release();
			return 1'b1;
		end
		note_end();
		return 1'b0;
	endfunction

	function automatic logic tick_step();
		logic done;
		if (len_q != 0) begin
			len_q = len_q - 8'd1;
			if (len_q == 0) begin
				note_end();
				return 1'b0;
			end
		end
		if (timer_q != 0) begin
			timer_q = timer_q - 3'd1;
			if (timer_q == 0) begin
				if (vol_q == tgt_q) begin
					done = 1'b1;
				end else if (dir_up_q) begin
					if (vol_q == 4'd15) begin
						done = 1'b1;
					end else begin
						vol_q = vol_q + 4'd1;
						done = (vol_q == tgt_q);
					end
				end else begin
					if (vol_q == 4'd0) begin
						done = 1'b1;
					end else begin
						vol_q = vol_q - 4'd1;
						done = (vol_q == tgt_q);
					end
				end
				if (done)
					return next_stage();
				timer_q = pace_q;
			end
		end
		return 1'b0;
	endfunction

	function automatic result_t envelope_step(input mode_t m, input logic [3:0] v);
		logic    adv;
		result_t r;
		adv = 1'b0;
		case (m)
			MODE_TICK: begin
				adv = tick_step();
			end
			MODE_NOTE_ON: begin
				len_q = (env_cfg.note_length != 0) ?
					8'((64 - int'(env_cfg.note_length)) * 4) : 8'd0;
				stage_q = ST_ATTACK;
				dir_up_q = 1'b1;
				pace_q = env_cfg.attack_pace;
				timer_q = env_cfg.attack_pace;
				vol_q = (env_cfg.attack_pace != 0) ? 4'd0 : v;
				tgt_q = v;
			end
			MODE_NOTE_OFF: begin
				if (stage_q != ST_RELEASE) begin
					if (vol_q == 0 || env_cfg.release_pace == 0) begin
						stage_q = ST_RELEASE;
						note_end();
					end else begin
						start_release();
					end
				end
			end
			default: begin
				note_end();
			end
		endcase
		r.level = vol_q;
		r.phase = stage_q;
		r.rising = dir_up_q;
		r.phase_advanced = adv;
		return r;
	endfunction

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			cmd_bus.mode <= MODE_TICK;
			cmd_bus.note_volume <= '0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				envelope_expected.push_back(envelope_step(pending_cmds[0].mode,
					pending_cmds[0].note_volume));
				void'(pending_cmds.pop_front());
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd_bus.valid <= 1'b1;
					cmd_bus.mode <= pending_cmds[0].mode;
					cmd_bus.note_volume <= pending_cmds[0].note_volume;
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_count <= 90;
		end else if (hold_count != 0) begin
			hold_count <= hold_count - 1;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_bus.ready <= 1'b0;
		end else begin
			if (env_bus.valid && env_bus.ready) begin
				if (envelope_expected.size() == 0) begin
					$error("result item with no expectation");
					error_count++;
				end else begin
					if (env_bus.level !== envelope_expected[0].level) begin
						$error("level: expected %0d, got %0d",
							envelope_expected[0].level, env_bus.level);
						error_count++;
					end
					if (env_bus.phase !== envelope_expected[0].phase) begin
						$error("phase: expected %0d, got %0d",
							envelope_expected[0].phase, env_bus.phase);
						error_count++;
					end
					if (env_bus.rising !== envelope_expected[0].rising) begin
						$error("rising: expected %0d, got %0d",
							envelope_expected[0].rising, env_bus.rising);
						error_count++;
					end
					if (env_bus.phase_advanced !== envelope_expected[0].phase_advanced) begin
						$error("phase_advanced: expected %0d, got %0d",
							envelope_expected[0].phase_advanced, env_bus.phase_advanced);
						error_count++;
					end
					void'(envelope_expected.pop_front());
				end
			end
			env_bus.ready <= (hold_count == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic queue_cmd(input mode_t m, input logic [3:0] v);
		cmd_item_t c;
		c.mode = m;
		c.note_volume = v;
		pending_cmds.push_back(c);
	endtask

	task automatic wait_quiet();
		while (pending_cmds.size() != 0 || envelope_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [DataWidth-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ATTACK_PACE:  env_cfg.attack_pace = value[2:0];
			REG_DECAY_PACE:   env_cfg.decay_pace = value[2:0];
			REG_SUSTAIN_DROP: env_cfg.sustain_drop = value[3:0];
			REG_RELEASE_PACE: env_cfg.release_pace = value[2:0];
			default:          env_cfg.note_length = value[5:0];
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(input int ap, input int dp, input int sd, input int rp,
		input int nl);
		apb_write(REG_ATTACK_PACE, DataWidth'(ap));
		apb_write(REG_DECAY_PACE, DataWidth'(dp));
		apb_write(REG_SUSTAIN_DROP, DataWidth'(sd));
		apb_write(REG_RELEASE_PACE, DataWidth'(rp));
		apb_write(REG_NOTE_LENGTH, DataWidth'(nl));
	endtask

	function automatic int pick_pace();
		case ($urandom_range(7))
			0:       return 0;
			1:       return 7;
			default: return $urandom_range(1, 2);
		endcase
	endfunction

	function automatic int pick_length();
		case ($urandom_range(5))
			0:       return 63;
			1:       return 1;
			2:       return $urandom_range(40, 62);
			default: return 0;
		endcase
	endfunction

	// mostly well-formed notes with random content, some noise
	task automatic queue_notes(input int n_items);
		int count;
		int r;
		int k;
		count = 0;
		while (count < n_items) begin
			r = $urandom_range(99);
			if (r < 10) begin
				queue_cmd(mode_t'($urandom_range(3)), 4'($urandom_range(15)));
				count++;
			end else begin
				queue_cmd(MODE_NOTE_ON, 4'($urandom_range(15)));
				k = $urandom_range(4, 50);
				repeat (k) queue_cmd(MODE_TICK, 4'($urandom_range(15)));
				count += k + 2;
				queue_cmd((r < 85) ? MODE_NOTE_OFF : MODE_KILL, 4'($urandom_range(15)));
				k = $urandom_range(0, 25);
				repeat (k) queue_cmd(MODE_TICK, 4'($urandom_range(15)));
				count += k;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: immediate attack, everything else skipped
		queue_cmd(MODE_NOTE_ON, 4'd15);
		queue_cmd(MODE_TICK, 4'd0);
		queue_cmd(MODE_NOTE_OFF, 4'd0);
		queue_cmd(MODE_NOTE_OFF, 4'd15);
		queue_cmd(MODE_NOTE_ON, 4'd0);
		queue_cmd(MODE_KILL, 4'd15);
		queue_cmd(MODE_TICK, 4'd15);
		wait_quiet();

		// shortest length timer, expiry right after entering decay
		set_config(1, 1, 15, 7, 63);
		queue_cmd(MODE_NOTE_ON, 4'd3);
		repeat (4) queue_cmd(MODE_TICK, 4'd0);
		// step at target, then note off at level 0
		queue_cmd(MODE_NOTE_ON, 4'd0);
		queue_cmd(MODE_TICK, 4'd0);
		queue_cmd(MODE_TICK, 4'd0);
		queue_cmd(MODE_NOTE_OFF, 4'd0);
		queue_cmd(MODE_KILL, 4'd0);
		wait_quiet();

		// immediate attack holding, note off into release, kill mid-release
		set_config(0, 0, 0, 1, 0);
		queue_cmd(MODE_NOTE_ON, 4'd15);
		queue_cmd(MODE_TICK, 4'd0);
		queue_cmd(MODE_NOTE_OFF, 4'd0);
		queue_cmd(MODE_TICK, 4'd0);
		queue_cmd(MODE_KILL, 4'd0);
		wait_quiet();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			for (int ch = 0; ch < 5; ch++) begin
				wait_quiet();
				if (ph == 1 && ch == 0)
					set_config(7, 7, 15, 7, 63);
				else if (ph == 2 && ch == 0)
					set_config(0, 0, 0, 0, 0);
				else
					set_config(pick_pace(), pick_pace(), $urandom_range(15), pick_pace(),
						pick_length());
				if (ph == 0 && ch == 2) begin
					// back up the block while the receiver holds off
					queue_notes(40);
					hold_req = ~hold_req;
				end
				queue_notes(25);
			end
		end

		wait_quiet();
		repeat (8) @(negedge clk);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule
`default_nettype wire
